// ----- design/drfl_pkg.sv -----
`default_nettype none
package drfl_pkg;
  localparam int KEY_W = 28;
  localparam int RATE_W = 48;
  localparam int AMT_W = 32;
  localparam int PROD_W = 58;
  localparam int ST_W = 3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_DATE  = 3'd1;
  localparam logic [ST_W-1:0] ST_NEGATIVE  = 3'd2;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 3'd3;
  localparam logic [ST_W-1:0] ST_TOO_EARLY = 3'd4;
  localparam logic [ST_W-1:0] ST_STORED    = 3'd5;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [31:0] AMOUNT_LIMIT = 32'd1000;

  typedef struct packed {
    logic          opcode;
    logic [13:0]   year;
    logic [6:0]    month;
    logic [6:0]    day;
    logic [AMT_W-1:0]  amount;
    logic [RATE_W-1:0] entry_rate;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [PROD_W-1:0] product;
  } out_item_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // capture input item, reset search bounds
    logic rd_mid;     // read memory at mid
    logic step;       // narrow search with read data
    logic rd_shift;   // read entry i-1 for shifting
    logic wr_shift;   // write shifted entry at i, i--
    logic wr_new;     // write new entry at pos
    logic wr_over;    // overwrite rate at pos
    logic rd_found;   // read rate at found position
    logic mul_lo;     // first partial product
    logic mul_hi;     // second partial product
    logic finish;     // form the result
    logic [ST_W-1:0] fin_status;
  } cmd_t;

  typedef struct packed {
    logic       is_query;
    logic       date_bad;
    logic       amt_neg;
    logic       amt_big;
    logic       search_done;
    logic       exact;
    logic       found;
    logic       full;
    logic       shift_done;
  } sts_t;

  function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
    logic [4:0] d;
    begin
      case (m)
        7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
        7'd4, 7'd6, 7'd9, 7'd11: d = 5'd30;
        7'd2: d = leap ? 5'd29 : 5'd28;
        default: d = 5'd0;
      endcase
      return d;
    end
  endfunction
endpackage
`default_nettype wire

// ----- design/drfl_if.sv -----
`default_nettype none
interface drfl_in_if;
  logic valid;
  logic ready;
  drfl_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drfl_out_if;
  logic valid;
  logic ready;
  drfl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/dated_rate_floor_lookup.sv -----
`default_nettype none
// sequence: a query is checked, binary-searched and multiplied, and a rejected query skips
// the search and multiply; an insert is binary-searched, then shifts entries above the gap
// up one at a time and writes the new date into the gap
// one item at a time: the next item is accepted only after the result has been taken
// reset: synchronous active-low rst_n clears control and entry count;
// table contents are not cleared
module dated_rate_floor_lookup #(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  drfl_in_if.sink in_ch,
  drfl_out_if.source out_ch
);
  import drfl_pkg::*;
  cmd_t cmd;
  sts_t sts;
  out_item_t res;
  logic in_rdy, out_vld;

  drfl_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_ch.valid && in_rdy),
    .out_fire(out_vld && out_ch.ready),
    .sts, .cmd, .in_rdy, .out_vld
  );

  drfl_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .in_item(in_ch.data), .cmd, .sts, .res
  );

  assign in_ch.ready = in_rdy;
  assign out_ch.valid = out_vld;
  assign out_ch.data = res;
endmodule
`default_nettype wire

// ----- design/drfl_datapath.sv -----
`default_nettype none
module drfl_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  drfl_pkg::in_item_t in_item,
  input  drfl_pkg::cmd_t cmd,
  output drfl_pkg::sts_t sts,
  output drfl_pkg::out_item_t res
);
  import drfl_pkg::*;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_W+RATE_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+RATE_W-1:0] rd_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] lo_r, hi_r, idx_r;
  logic [KEY_W-1:0] key_r;
  logic [RATE_W-1:0] rate_r;
  logic [AMT_W-1:0] amt_r;
  logic op_r, bad_r;
  logic [CW-1:0] pos_r;
  logic [PROD_W-1:0] acc_r;
  logic [63:0] pp_r;

  logic [CW-1:0] mid;
  logic [AW-1:0] addr;
  logic [KEY_W-1:0] rd_key;
  logic [RATE_W-1:0] rd_rate;
  logic [26:0] yq_prod;
  logic [7:0] yq;
  logic [13:0] yq100;
  logic century;
  logic leap;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key = rd_r[KEY_W+RATE_W-1:RATE_W];
  assign rd_rate = rd_r[RATE_W-1:0];

  // year/100 by reciprocal multiply, exact for any 14-bit year
  assign yq_prod = 27'(in_item.year) * 27'd5243;
  assign yq = yq_prod[26:19];
  assign yq100 = {6'd0, yq} * 14'd100;
  assign century = (yq100 == in_item.year);
  assign leap = (in_item.year[1:0] == 2'd0) && (!century || (yq[1:0] == 2'd0));

  always_comb begin
    addr = mid[AW-1:0];
    if (cmd.rd_shift) addr = AW'(idx_r - CW'(1));
    else if (cmd.wr_shift) addr = idx_r[AW-1:0];
    else if (cmd.wr_new || cmd.wr_over) addr = pos_r[AW-1:0];
    else if (cmd.rd_found) addr = AW'(pos_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_shift) mem[addr] <= rd_r;
    else if (cmd.wr_new || cmd.wr_over) mem[addr] <= {key_r, rate_r};
    else if (cmd.rd_mid || cmd.rd_shift || cmd.rd_found) rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr_new) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= {in_item.year, in_item.month, in_item.day};
      rate_r <= in_item.entry_rate;
      amt_r <= in_item.amount;
      op_r <= in_item.opcode;
      bad_r <= (in_item.day == 7'd0) ||
               ({2'b0, in_item.day} > month_days(in_item.month, leap));
      lo_r <= '0;
      hi_r <= count_r;
      idx_r <= count_r;
    end
    if (cmd.step) begin
      if (rd_key < key_r) lo_r <= mid + CW'(1);
      else hi_r <= mid;
    end
    if (cmd.wr_shift) idx_r <= idx_r - CW'(1);
    if (cmd.rd_mid && lo_r == hi_r) begin
      // search settled: lo is first entry not below key, rd_r holds it
      pos_r <= lo_r;
    end
    if (cmd.mul_lo) begin
      pp_r <= 64'(amt_r) * 64'(rd_rate[23:0]);
    end
    if (cmd.mul_hi) begin
      acc_r <= PROD_W'(((pp_r << 0) >> FRAC_BITS)
               + ((64'(amt_r) * 64'(rd_rate[RATE_W-1:24])) << (24 - FRAC_BITS)));
    end
    if (cmd.finish) begin
      res.status <= cmd.fin_status;
      res.product <= (cmd.fin_status == ST_OK) ? acc_r : '0;
    end
  end

  // exactness evaluated when search settles; memory read of pos is in rd_r
  logic pos_valid;
  assign pos_valid = (pos_r < count_r);
  assign sts.is_query = op_r;
  assign sts.date_bad = bad_r;
  assign sts.amt_neg = amt_r[AMT_W-1];
  assign sts.amt_big = {1'b0, amt_r} > (33'(AMOUNT_LIMIT) << FRAC_BITS);
  assign sts.search_done = (lo_r == hi_r);
  assign sts.exact = pos_valid && (rd_key == key_r);
  // an entry exists below pos
  assign sts.found = (pos_r != '0);
  assign sts.full = (count_r >= CW'(TABLE_DEPTH));
  assign sts.shift_done = (idx_r == pos_r);
endmodule
`default_nettype wire

// ----- design/drfl_ctrl.sv -----
`default_nettype none
module drfl_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  drfl_pkg::sts_t sts,
  output drfl_pkg::cmd_t cmd,
  output logic in_rdy,
  output logic out_vld
);
  import drfl_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_RD = 4'd2, S_STEP = 4'd3,
    S_DEC = 4'd4, S_SHRD = 4'd5, S_SHWR = 4'd6, S_ML = 4'd8,
    S_MH = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11, S_PREV = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [ST_W-1:0] st_r, st_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    st_nxt = st_r;
    case (state_r)
      S_IDLE: if (in_fire) begin cmd.load = 1'b1; state_nxt = S_CHK; end
      S_CHK: begin
        if (sts.is_query && sts.date_bad) begin st_nxt = ST_BAD_DATE; state_nxt = S_FIN; end
        else if (sts.is_query && sts.amt_neg) begin st_nxt = ST_NEGATIVE; state_nxt = S_FIN; end
        else if (sts.is_query && sts.amt_big) begin st_nxt = ST_TOO_LARGE; state_nxt = S_FIN; end
        else state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd_mid = 1'b1;
        state_nxt = sts.search_done ? S_DEC : S_STEP;
      end
      S_STEP: begin cmd.step = 1'b1; state_nxt = S_RD; end
      S_DEC: begin
        if (!sts.is_query) begin
          if (sts.exact) begin cmd.wr_over = 1'b1; st_nxt = ST_STORED; state_nxt = S_FIN; end
          else if (sts.full) begin st_nxt = ST_FULL; state_nxt = S_FIN; end
          else if (sts.shift_done) begin
            cmd.wr_new = 1'b1; st_nxt = ST_STORED; state_nxt = S_FIN;
          end else state_nxt = S_SHRD;
        end else begin
          if (sts.exact) state_nxt = S_ML;
          else state_nxt = S_PREV;
        end
      end
      S_PREV: begin
        // entry before pos, if any
        if (!sts.found) begin
          st_nxt = ST_TOO_EARLY;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_found = 1'b1;
          state_nxt = S_ML;
        end
      end
      S_SHRD: begin
        if (sts.shift_done) begin
          cmd.wr_new = 1'b1; st_nxt = ST_STORED; state_nxt = S_FIN;
        end else begin
          cmd.rd_shift = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        state_nxt = S_SHRD;
      end
      S_ML: begin cmd.mul_lo = 1'b1; state_nxt = S_MH; end
      S_MH: begin cmd.mul_hi = 1'b1; st_nxt = ST_OK; state_nxt = S_FIN; end
      S_FIN: begin cmd.finish = 1'b1; cmd.fin_status = st_r; state_nxt = S_OUT; end
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_rdy = (state_r == S_IDLE);
  assign out_vld = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_vld |-> !in_rdy)
    else $error("result and input both open");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (state_r == S_OUT))
    else $error("finish did not present result");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_CHK))
    else $error("accepted item not checked");
endmodule
`default_nettype wire
